>>> src/rrst_pkg.sv
package rrst_pkg;

    localparam int ACTION_W   = 2;
    localparam int CAP_W      = 5;
    localparam int SLOT_IDX_W = 4;
    localparam int OCC_W      = 5;
    localparam int MASK_W     = 16;
    localparam int FIELD_BITS = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

endpackage

>>> src/rrst_req_if.sv
interface rrst_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                               valid;
    logic                               ready;
    rrst_pkg::action_t                  action;
    logic [VALUE_BITS-1:0]              entry_value;
    logic [rrst_pkg::MASK_W-1:0]        accept_mask;

    modport source (output valid, output action, output entry_value, output accept_mask,
                    input ready);
    modport sink   (input valid, input action, input entry_value, input accept_mask,
                    output ready);
endinterface

>>> src/rrst_rsp_if.sv
interface rrst_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [rrst_pkg::SLOT_IDX_W-1:0]    slot_index;
    logic [VALUE_BITS-1:0]              entry_out;
    logic [rrst_pkg::OCC_W-1:0]         occupied;

    modport source (output valid, output ok, output slot_index, output entry_out,
                    output occupied, input ready);
    modport sink   (input valid, input ok, input slot_index, input entry_out,
                    input occupied, output ready);
endinterface

>>> src/round_robin_slot_table.sv
// Channel  | Dir | Payload                                   | Handshake
// ---------+-----+-------------------------------------------+-------------
// req      | in  | action, entry_value, accept_mask          | valid/ready
// rsp      | out | ok, slot_index, entry_out, occupied       | valid/ready
// cfg      | in  | cfg_wr_data (capacity)                    | cfg_wr_en
//
// An item is taken only while the sequencer is idle; one result item per input item.
// Append, remove and select walk the slot memory one read per cycle from the start slot
// until a slot qualifies or every slot has been read; a nop, a zero append or remove
// value and an append to a full table skip the walk. The single read port sets the pace.
// Reset clears the occupancy flags, count and pointer at once; no clearing pass.
// A result waiting on rsp does not block the next acceptance; a scan that finishes while
// the output register is still full holds until it drains.
module round_robin_slot_table #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rrst_req_if.sink                    req,
    rrst_rsp_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [rrst_pkg::CAP_W-1:0]  cfg_wr_data
);

    localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int CMP_W      = (CNT_W > rrst_pkg::CAP_W) ? CNT_W : rrst_pkg::CAP_W;
    localparam int EFF_BITS   = (VALUE_BITS < rrst_pkg::FIELD_BITS) ? VALUE_BITS
                                                                    : rrst_pkg::FIELD_BITS;
    localparam int MASK_SLOTS = (SLOTS < rrst_pkg::MASK_W) ? SLOTS : rrst_pkg::MASK_W;
    localparam logic [VALUE_BITS-1:0] VAL_MASK = {VALUE_BITS{1'b1}} >> (VALUE_BITS - EFF_BITS);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // control and result registers
    state_t                         state_reg,    state_next;
    rrst_pkg::action_t              op_reg,       op_next;
    logic [VALUE_BITS-1:0]          val_reg,      val_next;
    logic [rrst_pkg::MASK_W-1:0]    mask_reg,     mask_next;
    logic                           skip_reg,     skip_next;
    logic [AW-1:0]                  addr_reg,     addr_next;
    logic [CNT_W-1:0]               issued_reg,   issued_next;
    logic                           rd_pend_reg,  rd_pend_next;
    logic [AW-1:0]                  rd_addr_reg,  rd_addr_next;
    logic [SLOTS-1:0]               valid_reg,    valid_next;
    logic [CNT_W-1:0]               count_reg,    count_next;
    logic [AW-1:0]                  ptr_reg,      ptr_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_ok_reg,   out_ok_next;
    logic [rrst_pkg::SLOT_IDX_W-1:0] out_slot_reg, out_slot_next;
    logic [VALUE_BITS-1:0]          out_entry_reg, out_entry_next;
    logic [rrst_pkg::OCC_W-1:0]     out_occ_reg,  out_occ_next;
    logic [rrst_pkg::CAP_W-1:0]     cap_reg;

    // slot memory
    logic [VALUE_BITS-1:0]          mem [SLOTS];
    logic [VALUE_BITS-1:0]          rd_data_reg;

    logic                           accept;
    logic [VALUE_BITS-1:0]          val_in;
    logic [CMP_W-1:0]               cap_eff;
    logic                           full;
    logic [SLOTS-1:0]               mask_slots;
    logic                           scanning;
    logic                           cond;
    logic                           hit;
    logic                           fail;
    logic                           fin_req;
    logic                           out_free;
    logic                           fin;
    logic                           issue;
    logic                           mem_we;

    assign accept   = req.valid && req.ready;
    assign val_in   = req.entry_value & VAL_MASK;
    assign scanning = (state_reg == ST_SCAN);
    assign out_free = !out_valid_reg || rsp.ready;

    // capacity above the slot count behaves as the slot count
    assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(cap_reg);
    assign full    = (CMP_W'(count_reg) >= cap_eff);

    // slots at 16 and above never carry a mask bit
    always_comb
    begin
        mask_slots = '0;
        for (int i = 0; i < MASK_SLOTS; i++)
        begin
            mask_slots[i] = mask_reg[i];
        end
    end

    // qualification of the slot whose data has just come back
    always_comb
    begin
        case (op_reg)
            rrst_pkg::ACT_APPEND: cond = !valid_reg[rd_addr_reg];
            rrst_pkg::ACT_REMOVE: cond = valid_reg[rd_addr_reg] && (rd_data_reg == val_reg);
            rrst_pkg::ACT_SELECT: cond = valid_reg[rd_addr_reg] && mask_slots[rd_addr_reg];
            default:              cond = 1'b0;
        endcase
    end

    assign hit     = scanning && !skip_reg && rd_pend_reg && cond;
    assign fail    = scanning && (skip_reg ||
                     (rd_pend_reg && !cond && (issued_reg == CNT_W'(SLOTS))));
    assign fin_req = hit || fail;
    assign fin     = fin_req && out_free;
    assign issue   = scanning && !skip_reg && !fin_req && (issued_reg != CNT_W'(SLOTS));
    assign mem_we  = fin && hit && (op_reg == rrst_pkg::ACT_APPEND);

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.slot_index = out_slot_reg;
    assign rsp.entry_out  = out_entry_reg;
    assign rsp.occupied   = out_occ_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        mask_next      = mask_reg;
        skip_next      = skip_reg;
        addr_next      = addr_reg;
        issued_next    = issued_reg;
        rd_pend_next   = rd_pend_reg;
        rd_addr_next   = rd_addr_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_slot_next  = out_slot_reg;
        out_entry_next = out_entry_reg;
        out_occ_next   = out_occ_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next   = ST_SCAN;
            op_next      = req.action;
            val_next     = val_in;
            mask_next    = req.accept_mask;
            issued_next  = '0;
            rd_pend_next = 1'b0;
            addr_next    = (req.action == rrst_pkg::ACT_SELECT) ? ptr_reg : '0;
            case (req.action)
                rrst_pkg::ACT_APPEND: skip_next = (val_in == '0) || full;
                rrst_pkg::ACT_REMOVE: skip_next = (val_in == '0);
                rrst_pkg::ACT_SELECT: skip_next = 1'b0;
                default:              skip_next = 1'b1;
            endcase
        end

        if (issue)
        begin
            rd_pend_next = 1'b1;
            rd_addr_next = addr_reg;
            issued_next  = issued_reg + 1'b1;
            addr_next    = (addr_reg == AW'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
        end

        if (fin)
        begin
            state_next     = ST_IDLE;
            rd_pend_next   = 1'b0;
            out_valid_next = 1'b1;
            out_ok_next    = hit;
            out_slot_next  = hit ? rrst_pkg::SLOT_IDX_W'(rd_addr_reg) : '0;
            out_entry_next = '0;
            if (hit)
            begin
                case (op_reg)
                    rrst_pkg::ACT_APPEND:
                    begin
                        valid_next[rd_addr_reg] = 1'b1;
                        count_next              = count_reg + 1'b1;
                    end
                    rrst_pkg::ACT_REMOVE:
                    begin
                        valid_next[rd_addr_reg] = 1'b0;
                        count_next              = count_reg - 1'b1;
                    end
                    rrst_pkg::ACT_SELECT:
                    begin
                        out_entry_next = rd_data_reg;
                        ptr_next       = (rd_addr_reg == AW'(SLOTS - 1)) ? '0
                                                                         : rd_addr_reg + 1'b1;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            out_occ_next = rrst_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= rrst_pkg::ACT_NOP;
            val_reg       <= '0;
            mask_reg      <= '0;
            skip_reg      <= 1'b0;
            addr_reg      <= '0;
            issued_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_slot_reg  <= '0;
            out_entry_reg <= '0;
            out_occ_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            mask_reg      <= mask_next;
            skip_reg      <= skip_next;
            addr_reg      <= addr_next;
            issued_reg    <= issued_next;
            rd_pend_reg   <= rd_pend_next;
            rd_addr_reg   <= rd_addr_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_slot_reg  <= out_slot_next;
            out_entry_reg <= out_entry_next;
            out_occ_reg   <= out_occ_next;
        end
    end

    // capacity register; write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= rrst_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // slot memory: one write, one registered read; a slot is only trusted when flagged
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[rd_addr_reg] <= val_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count out of step with slot flags");

    a_append_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && hit && op_reg == rrst_pkg::ACT_APPEND) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("successful append did not raise the count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin))
        else $error("result item appeared without a finished scan");

    a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> scanning)
        else $error("read pending outside a scan");

endmodule

>>> tb/round_robin_slot_table_tb.sv
module round_robin_slot_table_tb;

    localparam int NUM_SLOTS  = 16;
    localparam int VAL_W      = 32;
    // Quiet cycles allowed before the run is declared hung. The longest legal quiet stretch
    // is the long receiver hold-off (LONG_HOLD) plus one scan and a sender gap.
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int POOL_SIZE   = 12;

    // One result item as it appears on rsp
    typedef struct packed {
        logic                            ok;
        logic [rrst_pkg::SLOT_IDX_W-1:0] slot;
        logic [VAL_W-1:0]                entry;
        logic [rrst_pkg::OCC_W-1:0]      occ;
    } slot_result_t;

    // Mirror of the slot table plus the queue of results still owed by the block.
    class slot_table_tracker;
        logic [VAL_W-1:0]                slot_vals [NUM_SLOTS];
        logic [rrst_pkg::OCC_W-1:0]      occ_count;
        logic [rrst_pkg::SLOT_IDX_W-1:0] rot_ptr;
        logic [rrst_pkg::CAP_W-1:0]      capacity;
        slot_result_t                    owed_results[$];
        int                              mismatches;

        function new();
            foreach (slot_vals[i])
                slot_vals[i] = '0;
            occ_count  = '0;
            rot_ptr    = '0;
            capacity   = rrst_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [rrst_pkg::CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Work out the result of one accepted item and update the mirror
        function void note_request(rrst_pkg::action_t act, logic [VAL_W-1:0] val,
                                   logic [rrst_pkg::MASK_W-1:0] msk);
            slot_result_t res;
            int           eff_cap;
            int           s;
            res      = '0;
            eff_cap  = (capacity > NUM_SLOTS) ? NUM_SLOTS : capacity;
            case (act)
                rrst_pkg::ACT_APPEND:
                    if (val != '0 && occ_count < eff_cap)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (slot_vals[i] == '0)
                            begin
                                slot_vals[i] = val;
                                occ_count++;
                                res.ok   = 1'b1;
                                res.slot = i[rrst_pkg::SLOT_IDX_W-1:0];
                                break;
                            end
                        end
                    end
                rrst_pkg::ACT_REMOVE:
                    if (val != '0)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (slot_vals[i] == val)
                            begin
                                slot_vals[i] = '0;
                                if (occ_count > 0)
                                    occ_count--;
                                res.ok   = 1'b1;
                                res.slot = i[rrst_pkg::SLOT_IDX_W-1:0];
                                break;
                            end
                        end
                    end
                rrst_pkg::ACT_SELECT:
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        s = (rot_ptr + i) % NUM_SLOTS;
                        if (slot_vals[s] != '0 && msk[s])
                        begin
                            res.ok    = 1'b1;
                            res.slot  = s[rrst_pkg::SLOT_IDX_W-1:0];
                            res.entry = slot_vals[s];
                            rot_ptr   = rrst_pkg::SLOT_IDX_W'((s + 1) % NUM_SLOTS);
                            break;
                        end
                    end
                default: ;
            endcase
            res.occ = occ_count;
            owed_results.push_back(res);
        endfunction

        function void check_response(slot_result_t got);
            slot_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result item arrived with nothing outstanding");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                mismatches++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.entry !== want.entry)
            begin
                $error("entry_out: expected %h, got %h", want.entry, got.entry);
                mismatches++;
            end
            if (got.occ !== want.occ)
            begin
                $error("occupied: expected %0d, got %0d", want.occ, got.occ);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [rrst_pkg::CAP_W-1:0]  cfg_wr_data;

    rrst_req_if #(.VALUE_BITS(VAL_W)) req_ch ();
    rrst_rsp_if #(.VALUE_BITS(VAL_W)) rsp_ch ();

    round_robin_slot_table #(
        .SLOTS      (NUM_SLOTS),
        .VALUE_BITS (VAL_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    slot_table_tracker tracker = new();

    // Random idling on both channels; switched off for the closing stretch
    bit               idle_on;
    // Set by the stimulus to ask the receiver for one long hold-off
    bit               long_hold_req;
    int               quiet_cycles;
    logic [VAL_W-1:0] value_pool [POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitors: everything is sampled at the rising edge, i.e. the values the block saw.
    // The response is checked before the request is noted, so a same-edge pair never
    // sees its own expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                tracker.set_capacity(cfg_wr_data);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_response({rsp_ch.ok, rsp_ch.slot_index, rsp_ch.entry_out,
                                        rsp_ch.occupied});
            if (req_ch.valid && req_ch.ready)
                tracker.note_request(req_ch.action, req_ch.entry_value, req_ch.accept_mask);
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Receiver: short random stalls, plus one long hold-off on request so the block
    // fills its output register and stops taking items. One NBA to ready per edge.
    initial
    begin
        int hold_left;
        bit next_ready;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = (hold_left == 0);
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
                next_ready    = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left  = $urandom_range(1, 8);
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            rsp_ch.ready <= next_ready;
        end
    end

    // Offer one item and return at the edge where it is taken; valid stays high so
    // back-to-back items need no extra edge.
    task automatic send_item(rrst_pkg::action_t act, logic [VAL_W-1:0] val,
                             logic [rrst_pkg::MASK_W-1:0] msk);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.entry_value <= val;
        req_ch.accept_mask <= msk;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stop offering, let the monitor note the last item, wait for every owed result,
    // then a few spare cycles so the sequencer is surely idle before a register write.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [rrst_pkg::CAP_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly values from a small pool so that removes find their targets, with the odd
    // zero and the odd full-width random value.
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r <= 2)
            return $urandom;
        else
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
    endfunction

    function automatic logic [rrst_pkg::MASK_W-1:0] pick_mask();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3:    return rrst_pkg::MASK_W'(1) << $urandom_range(0, rrst_pkg::MASK_W-1);
            default: return rrst_pkg::MASK_W'($urandom);
        endcase
    endfunction

    // Random item: weighted towards append/remove/select, with a few nops. A remove whose
    // picked slot is occupied mostly aims at its value (the mirror may lag by an item in flight).
    task automatic send_random_item();
        int               pick;
        logic [VAL_W-1:0] held;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_item(rrst_pkg::ACT_APPEND, pick_value(), pick_mask());
        else if (pick < 70)
        begin
            held = tracker.slot_vals[$urandom_range(0, NUM_SLOTS-1)];
            if (held != '0 && $urandom_range(0, 9) < 7)
                send_item(rrst_pkg::ACT_REMOVE, held, pick_mask());
            else
                send_item(rrst_pkg::ACT_REMOVE, pick_value(), pick_mask());
        end
        else if (pick < 95)
            send_item(rrst_pkg::ACT_SELECT, $urandom, pick_mask());
        else
            send_item(rrst_pkg::ACT_NOP, $urandom, rrst_pkg::MASK_W'($urandom));
    endtask

    initial
    begin
        logic [rrst_pkg::CAP_W-1:0] phase_caps [8];

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= rrst_pkg::ACT_NOP;
        req_ch.entry_value <= '0;
        req_ch.accept_mask <= '0;
        idle_on            = 1'b1;
        long_hold_req      = 1'b0;

        value_pool[0] = '1;
        value_pool[1] = 32'd1;
        value_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            value_pool[i] = $urandom | 32'd1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset capacity of 16
        send_item(rrst_pkg::ACT_APPEND, '0, '0);               // zero value refused
        send_item(rrst_pkg::ACT_APPEND, '1, '0);               // slot 0
        send_item(rrst_pkg::ACT_APPEND, 32'd1, '1);            // slot 1
        send_item(rrst_pkg::ACT_APPEND, 32'h8000_0000, '0);    // slot 2
        send_item(rrst_pkg::ACT_SELECT, '0, '1);               // slot 0, pointer to 1
        send_item(rrst_pkg::ACT_SELECT, '0, '0);               // empty mask fails, pointer kept
        send_item(rrst_pkg::ACT_SELECT, '0, 16'h0001);         // wraps round to slot 0
        send_item(rrst_pkg::ACT_SELECT, '0, 16'h8000);         // slot 15 empty, fails
        send_item(rrst_pkg::ACT_REMOVE, '0, '0);               // zero never matches
        send_item(rrst_pkg::ACT_REMOVE, 32'h0001_2345, '0);    // absent value
        send_item(rrst_pkg::ACT_REMOVE, 32'd1, '0);            // hole at slot 1
        send_item(rrst_pkg::ACT_SELECT, '0, '1);               // skips the hole
        send_item(rrst_pkg::ACT_APPEND, 32'd7, '0);            // refills slot 1
        send_item(rrst_pkg::ACT_NOP, '1, '1);                  // nop reports the count only
        send_item(rrst_pkg::ACT_SELECT, '0, '1);
        drain_results();

        // Capacity lowered below the count: appends refused, entries kept
        write_capacity(rrst_pkg::CAP_W'(2));
        send_item(rrst_pkg::ACT_APPEND, 32'd5, '0);
        send_item(rrst_pkg::ACT_REMOVE, '1, '0);
        send_item(rrst_pkg::ACT_APPEND, 32'd9, '0);
        send_item(rrst_pkg::ACT_SELECT, '0, '1);
        drain_results();

        // Capacity zero: every append refused
        write_capacity(rrst_pkg::CAP_W'(0));
        send_item(rrst_pkg::ACT_APPEND, 32'd3, '0);
        send_item(rrst_pkg::ACT_REMOVE, 32'd7, '0);
        drain_results();

        // Capacity above the slot count acts as full size
        write_capacity(rrst_pkg::CAP_W'(31));
        send_item(rrst_pkg::ACT_APPEND, 32'd3, '0);
        drain_results();

        // Random phases, each at its own capacity; extremes included
        phase_caps[0] = rrst_pkg::CAP_W'(1);
        phase_caps[1] = rrst_pkg::CAP_W'(16);
        phase_caps[2] = rrst_pkg::CAP_W'($urandom_range(2, 15));
        phase_caps[3] = rrst_pkg::CAP_W'(0);
        phase_caps[4] = rrst_pkg::CAP_W'(31);
        phase_caps[5] = rrst_pkg::CAP_W'(5);
        phase_caps[6] = rrst_pkg::CAP_W'(17);
        phase_caps[7] = rrst_pkg::CAP_W'(16);
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(phase_caps[p]);
            // Closing stretch runs flat out on both sides
            if (p == 7)
                idle_on = 1'b0;
            // Long receiver hold-off while the sender keeps offering
            if (p == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < 110; n++)
                send_random_item();
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
